// ===== src/sdci_pkg.sv =====
// Package for the SD card identification sequencer.
// Holds codes, register indexes, reset values and the result and config structs.
// No dependencies.
`default_nettype none

package sdci_pkg;

   localparam int KHZ_W         = 15;
   localparam int IFCOND_W      = 12;
   localparam int TRIES_W       = 10;
   localparam int CAP_W         = 22;
   localparam int RCA_W         = 16;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int REQ_TDATA_W   = 168;
   localparam int REQ_TUSER_W   = 2;
   localparam int RSP_TDATA_W   = 96;

   localparam logic [CSR_INDEX_W-1:0] REG_IDENT_KHZ    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_TRANSFER_KHZ = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_IFCOND       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ARG_HIGH_CAP = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_ARG_STD_CAP  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_TRIES        = 3'd5;

   localparam logic [KHZ_W-1:0]    RST_IDENT_KHZ    = 15'd240;
   localparam logic [KHZ_W-1:0]    RST_TRANSFER_KHZ = 15'd13000;
   localparam logic [IFCOND_W-1:0] RST_IFCOND       = 12'd426;
   localparam logic [31:0]         RST_ARG_HIGH_CAP = 32'd1090486272;
   localparam logic [31:0]         RST_ARG_STD_CAP  = 32'd16744448;
   localparam logic [TRIES_W-1:0]  RST_TRIES        = 10'd200;

   localparam logic [1:0] KIND_START    = 2'd0;
   localparam logic [1:0] KIND_COMPLETE = 2'd1;
   localparam logic [1:0] KIND_READ     = 2'd2;

   localparam logic [1:0] STATUS_OK = 2'd0;

   localparam logic [5:0] CMD_GO_IDLE    = 6'd0;
   localparam logic [5:0] CMD_ALL_CID    = 6'd2;
   localparam logic [5:0] CMD_SEND_RCA   = 6'd3;
   localparam logic [5:0] CMD_SELECT     = 6'd7;
   localparam logic [5:0] CMD_IF_COND    = 6'd8;
   localparam logic [5:0] CMD_SEND_CSD   = 6'd9;
   localparam logic [5:0] CMD_READ_BLOCK = 6'd17;
   localparam logic [5:0] CMD_OP_COND    = 6'd41;
   localparam logic [5:0] CMD_APP        = 6'd55;

   localparam logic [2:0] FAIL_NONE       = 3'd0;
   localparam logic [2:0] FAIL_CMD0       = 3'd1;
   localparam logic [2:0] FAIL_ACMD41_ERR = 3'd2;
   localparam logic [2:0] FAIL_ACMD41_TO  = 3'd3;
   localparam logic [2:0] FAIL_CMD2       = 3'd4;
   localparam logic [2:0] FAIL_CMD3       = 3'd5;
   localparam logic [2:0] FAIL_CMD7       = 3'd6;

   localparam logic [1:0] CARD_NONE = 2'd0;
   localparam logic [1:0] CARD_STD  = 2'd1;
   localparam logic [1:0] CARD_HIGH = 2'd2;

   localparam logic [1:0] CSD_V1 = 2'd0;
   localparam logic [1:0] CSD_V2 = 2'd1;

   typedef enum logic [3:0] {
      PH_IDLE   = 4'd0,
      PH_CMD0A  = 4'd1,
      PH_CMD0B  = 4'd2,
      PH_CMD8   = 4'd3,
      PH_CMD55  = 4'd4,
      PH_ACMD41 = 4'd5,
      PH_CMD2   = 4'd6,
      PH_CMD3   = 4'd7,
      PH_CMD9   = 4'd8,
      PH_CMD7   = 4'd9,
      PH_READY  = 4'd10,
      PH_FAILED = 4'd11
   } phase_type;

   typedef enum logic [1:0] {
      CTL_IDLE = 2'd0,
      CTL_DIV  = 2'd1,
      CTL_OUT  = 2'd2
   } ctl_type;

   typedef struct packed {
      logic [KHZ_W-1:0]    ident_khz;
      logic [KHZ_W-1:0]    transfer_khz;
      logic [IFCOND_W-1:0] ifcond;
      logic [31:0]         arg_high_cap;
      logic [31:0]         arg_std_cap;
      logic [TRIES_W-1:0]  tries;
   } cfg_type;

   // first member sits in the highest bits
   typedef struct packed {
      logic             read_rejected;
      logic [CAP_W-1:0] capacity_mb;
      logic [RCA_W-1:0] card_address;
      logic [1:0]       card_kind;
      logic [2:0]       fail_code;
      logic             init_finished;
      logic [7:0]       clock_divider;
      logic             clock_update;
      logic [31:0]      command_argument;
      logic [5:0]       command_index;
      logic             issue_command;
   } rsp_type;

endpackage

`default_nettype wire

// ===== src/sd_card_identification_sequencer.sv =====
// SD card identification sequencer, top level: command sequencer and result register.
// The result is registered and valid in the cycle after the input transfer; when the item
// reloads the clock divider, the result waits in the divide state for the bit-serial divider.
// One item at a time: a new input is taken only after the result has been transferred.
// Reset clears the phase, card state and registers to their defaults; no clearing pass.
// Depends on sdci_pkg, sdci_csr and sdci_divider.
`default_nettype none

module sd_card_identification_sequencer
   import sdci_pkg::*;
#(
   parameter int REF_CLOCK_KHZ = 26000,
   parameter int BLOCK_BYTES   = 512
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // status, resp_word0, resp_word1, resp_word2, resp_word3, block_address, zero pad
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // kind
   input  wire logic [REQ_TUSER_W-1:0] req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // issue_command, command_index, command_argument, clock_update, clock_divider,
   // init_finished, fail_code, card_kind, card_address, capacity_mb, read_rejected, zero pad
   output logic      [RSP_TDATA_W-1:0] rsp_tdata,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int NUM_W       = $clog2(REF_CLOCK_KHZ + 2**KHZ_W);
   localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);

   cfg_type cfg;

   ctl_type            ctl_ff, ctl_in;
   phase_type          phase_ff, phase_in;
   logic               echo_ff, echo_in;
   logic [TRIES_W-1:0] tries_ff, tries_in;
   logic [1:0]         type_ff, type_in;
   logic [RCA_W-1:0]   rca_ff, rca_in;
   logic [CAP_W-1:0]   cap_ff, cap_in;
   logic [2:0]         fail_ff, fail_in;
   rsp_type            rsp_ff, rsp_in;

   logic               accept;
   logic               ok;
   logic [1:0]         status;
   logic [31:0]        w0, w1, w2, w3, lba;
   logic [KHZ_W-1:0]   clk_khz;
   logic               need_clk;
   logic [TRIES_W-1:0] tries_dec;
   logic [21:0]        csd2_c;
   logic [22:0]        csd2_c1;
   logic [11:0]        csd1_c;
   logic [12:0]        csd1_c1;
   logic [4:0]         csd1_sh;
   logic [36:0]        csd1_bytes;
   logic               div_start;
   logic               div_done;
   logic [NUM_W-1:0]   div_numer;
   logic [NUM_W-1:0]   div_quo;
   logic [NUM_W:0]     div_plus3;
   logic [7:0]         div_field;

   sdci_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid & csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   sdci_divider #(
      .NUM_W (NUM_W),
      .DEN_W (KHZ_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (div_numer),
      .denom    (clk_khz),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign csr_ready  = 1'b1;
   assign req_tready = (ctl_ff == CTL_IDLE);
   assign rsp_tvalid = (ctl_ff == CTL_OUT);
   assign rsp_tdata  = {{(RSP_TDATA_W - $bits(rsp_type)){1'b0}}, rsp_ff};
   assign accept     = req_tvalid & req_tready;

   assign status = req_tdata[1:0];
   assign w0     = req_tdata[33:2];
   assign w1     = req_tdata[65:34];
   assign w2     = req_tdata[97:66];
   assign w3     = req_tdata[129:98];
   assign lba    = req_tdata[161:130];
   assign ok     = (status == STATUS_OK);

   assign tries_dec  = (tries_ff != '0) ? tries_ff - 1'b1 : '0;
   assign csd2_c     = {w2[5:0], w1[31:16]};
   assign csd2_c1    = {1'b0, csd2_c} + 23'd1;
   assign csd1_c     = {w2[9:0], w1[31:30]};
   assign csd1_c1    = {1'b0, csd1_c} + 13'd1;
   assign csd1_sh    = {2'b0, w1[17:15]} + {1'b0, w2[19:16]} + 5'd2;
   assign csd1_bytes = {24'b0, csd1_c1} << csd1_sh;

   assign div_numer = NUM_W'(REF_CLOCK_KHZ) + NUM_W'(clk_khz) - 1'b1;
   assign div_start = accept & need_clk;
   assign div_plus3 = {1'b0, div_quo} + (NUM_W + 1)'(3);
   assign div_field = (div_quo <= NUM_W'(2)) ? 8'd0 : div_plus3[9:2];

   always_comb begin
      phase_in = phase_ff;
      echo_in  = echo_ff;
      tries_in = tries_ff;
      type_in  = type_ff;
      rca_in   = rca_ff;
      cap_in   = cap_ff;
      fail_in  = fail_ff;
      clk_khz  = cfg.ident_khz;
      need_clk = 1'b0;
      rsp_in   = '0;

      case (req_tuser)
         KIND_START: begin
            echo_in  = 1'b0;
            tries_in = '0;
            type_in  = CARD_NONE;
            rca_in   = '0;
            cap_in   = '0;
            fail_in  = FAIL_NONE;
            need_clk = (cfg.ident_khz != '0);
            rsp_in.issue_command = 1'b1;
            rsp_in.command_index = CMD_GO_IDLE;
            phase_in = PH_CMD0A;
         end
         KIND_COMPLETE: begin
            case (phase_ff)
               PH_CMD0A: begin
                  if (!ok) begin
                     fail_in = FAIL_CMD0;
                     phase_in = PH_FAILED;
                     rsp_in.init_finished = 1'b1;
                  end else begin
                     rsp_in.issue_command = 1'b1;
                     rsp_in.command_index = CMD_GO_IDLE;
                     phase_in = PH_CMD0B;
                  end
               end
               PH_CMD0B: begin
                  rsp_in.issue_command    = 1'b1;
                  rsp_in.command_index    = CMD_IF_COND;
                  rsp_in.command_argument = {20'b0, cfg.ifcond};
                  phase_in = PH_CMD8;
               end
               PH_CMD8: begin
                  echo_in  = ok && (w0[IFCOND_W-1:0] == cfg.ifcond);
                  tries_in = cfg.tries;
                  if (cfg.tries == '0) begin
                     fail_in = FAIL_ACMD41_TO;
                     phase_in = PH_FAILED;
                     rsp_in.init_finished = 1'b1;
                  end else begin
                     rsp_in.issue_command = 1'b1;
                     rsp_in.command_index = CMD_APP;
                     phase_in = PH_CMD55;
                  end
               end
               PH_CMD55: begin
                  if (!ok) begin
                     fail_in = FAIL_ACMD41_ERR;
                     phase_in = PH_FAILED;
                     rsp_in.init_finished = 1'b1;
                  end else begin
                     rsp_in.issue_command    = 1'b1;
                     rsp_in.command_index    = CMD_OP_COND;
                     rsp_in.command_argument = echo_ff ? cfg.arg_high_cap : cfg.arg_std_cap;
                     phase_in = PH_ACMD41;
                  end
               end
               PH_ACMD41: begin
                  if (!ok) begin
                     fail_in = FAIL_ACMD41_ERR;
                     phase_in = PH_FAILED;
                     rsp_in.init_finished = 1'b1;
                  end else begin
                     tries_in = tries_dec;
                     if (w0[31]) begin
                        type_in = w0[30] ? CARD_HIGH : CARD_STD;
                        rsp_in.issue_command = 1'b1;
                        rsp_in.command_index = CMD_ALL_CID;
                        phase_in = PH_CMD2;
                     end else if (tries_dec == '0) begin
                        fail_in = FAIL_ACMD41_TO;
                        phase_in = PH_FAILED;
                        rsp_in.init_finished = 1'b1;
                     end else begin
                        rsp_in.issue_command = 1'b1;
                        rsp_in.command_index = CMD_APP;
                        phase_in = PH_CMD55;
                     end
                  end
               end
               PH_CMD2: begin
                  if (!ok) begin
                     fail_in = FAIL_CMD2;
                     phase_in = PH_FAILED;
                     rsp_in.init_finished = 1'b1;
                  end else begin
                     rsp_in.issue_command = 1'b1;
                     rsp_in.command_index = CMD_SEND_RCA;
                     phase_in = PH_CMD3;
                  end
               end
               PH_CMD3: begin
                  if (!ok) begin
                     fail_in = FAIL_CMD3;
                     phase_in = PH_FAILED;
                     rsp_in.init_finished = 1'b1;
                  end else begin
                     rca_in = w0[31:16];
                     rsp_in.issue_command    = 1'b1;
                     rsp_in.command_index    = CMD_SEND_CSD;
                     rsp_in.command_argument = {w0[31:16], 16'b0};
                     phase_in = PH_CMD9;
                  end
               end
               PH_CMD9: begin
                  if (ok && w3[31:30] == CSD_V2) begin
                     cap_in = csd2_c1[22:1];
                  end else if (ok && w3[31:30] == CSD_V1) begin
                     cap_in = {5'b0, csd1_bytes[36:20]};
                  end
                  rsp_in.issue_command    = 1'b1;
                  rsp_in.command_index    = CMD_SELECT;
                  rsp_in.command_argument = {rca_ff, 16'b0};
                  phase_in = PH_CMD7;
               end
               PH_CMD7: begin
                  if (!ok) begin
                     fail_in = FAIL_CMD7;
                     phase_in = PH_FAILED;
                     rsp_in.init_finished = 1'b1;
                  end else begin
                     clk_khz  = cfg.transfer_khz;
                     need_clk = (cfg.transfer_khz != '0);
                     rsp_in.init_finished = 1'b1;
                     phase_in = PH_READY;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
         KIND_READ: begin
            if (phase_ff == PH_READY) begin
               rsp_in.issue_command    = 1'b1;
               rsp_in.command_index    = CMD_READ_BLOCK;
               rsp_in.command_argument = (type_ff == CARD_HIGH) ? lba : (lba << BLOCK_SHIFT);
            end else begin
               rsp_in.read_rejected = 1'b1;
            end
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase

      rsp_in.clock_update = need_clk;
      rsp_in.fail_code    = fail_in;
      rsp_in.card_kind    = type_in;
      rsp_in.card_address = rca_in;
      rsp_in.capacity_mb  = cap_in;
   end

   always_comb begin
      ctl_in = ctl_ff;
      case (ctl_ff)
         CTL_IDLE: begin
            if (accept) begin
               ctl_in = need_clk ? CTL_DIV : CTL_OUT;
            end
         end
         CTL_DIV: begin
            if (div_done) begin
               ctl_in = CTL_OUT;
            end
         end
         CTL_OUT: begin
            if (rsp_tready) begin
               ctl_in = CTL_IDLE;
            end
         end
         default: begin
            ctl_in = CTL_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff   <= CTL_IDLE;
         phase_ff <= PH_IDLE;
         echo_ff  <= 1'b0;
         tries_ff <= '0;
         type_ff  <= CARD_NONE;
         rca_ff   <= '0;
         cap_ff   <= '0;
         fail_ff  <= FAIL_NONE;
      end else begin
         ctl_ff <= ctl_in;
         if (accept) begin
            phase_ff <= phase_in;
            echo_ff  <= echo_in;
            tries_ff <= tries_in;
            type_ff  <= type_in;
            rca_ff   <= rca_in;
            cap_ff   <= cap_in;
            fail_ff  <= fail_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end else if (ctl_ff == CTL_DIV && div_done) begin
         rsp_ff.clock_divider <= div_field;
      end
   end

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while a result is pending");

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (ctl_ff == CTL_DIV))
      else $error("divider finished outside the divide state");

   a_ready_card: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_READY) |-> (type_ff != CARD_NONE))
      else $error("ready phase without a card type");

   a_release: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready) |=> req_tready)
      else $error("block not ready after result transfer");

endmodule

`default_nettype wire

// ===== src/sdci_csr.sv =====
// Configuration register file of the SD card identification sequencer.
// Depends on sdci_pkg.
`default_nettype none

module sdci_csr
   import sdci_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   wr_en,
   input  wire logic [CSR_INDEX_W-1:0] wr_index,
   input  wire logic [CSR_DATA_W-1:0]  wr_data,
   output cfg_type                     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            REG_IDENT_KHZ:    cfg_in.ident_khz    = wr_data[KHZ_W-1:0];
            REG_TRANSFER_KHZ: cfg_in.transfer_khz = wr_data[KHZ_W-1:0];
            REG_IFCOND:       cfg_in.ifcond       = wr_data[IFCOND_W-1:0];
            REG_ARG_HIGH_CAP: cfg_in.arg_high_cap = wr_data;
            REG_ARG_STD_CAP:  cfg_in.arg_std_cap  = wr_data;
            REG_TRIES:        cfg_in.tries        = wr_data[TRIES_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ident_khz    <= RST_IDENT_KHZ;
         cfg_ff.transfer_khz <= RST_TRANSFER_KHZ;
         cfg_ff.ifcond       <= RST_IFCOND;
         cfg_ff.arg_high_cap <= RST_ARG_HIGH_CAP;
         cfg_ff.arg_std_cap  <= RST_ARG_STD_CAP;
         cfg_ff.tries        <= RST_TRIES;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== src/sdci_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the card clock divider.
// Depends on sdci_pkg only for the house import.
`default_nettype none

module sdci_divider
   import sdci_pkg::*;
#(
   parameter int NUM_W = 18,
   parameter int DEN_W = 15
)
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] numer,
   input  wire logic [DEN_W-1:0] denom,
   output logic                  done,
   output logic      [NUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_W - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   rem_shift;
   logic [DEN_W:0]   rem_sub;
   logic             fits;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[NUM_W-1]};
      rem_sub   = rem_shift - {1'b0, den_ff};
      fits      = rem_shift >= {1'b0, den_ff};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = numer;
         rem_in  = '0;
         den_in  = denom;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NUM_W-2:0], fits};
         rem_in = fits ? rem_sub[DEN_W-1:0] : rem_shift[DEN_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire
